[design/spq_pkg.sv]
`default_nettype none

package spq_pkg;

  // Number of entries the queue can hold.
  localparam int DEPTH = 16;
  // Width of the internal entry counter, wide enough to hold DEPTH itself.
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Fixed width of the count field in a result.
  localparam int COUNT_W = 5;

  localparam int PRIO_W = 16;
  localparam int TAG_W  = 16;

  // Request kinds.
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_POP_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL      = 2'd2;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic        [TAG_W-1:0]  tag;
  } entry_t;

  // Command broadcast to every cell in the same cycle.
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage

`default_nettype wire

[design/spq_cell.sv]
`default_nettype none

// One slot of the sorted chain. On an insert the cell either keeps its entry,
// takes the new entry, or takes its upper neighbor's entry as the list shifts
// down. On a pop it takes its lower neighbor's entry as the list shifts up.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t    new_entry,
  input  spq_pkg::entry_t    prev_entry,
  input  spq_pkg::entry_t    next_entry,
  input  logic               prev_take,
  input  logic               occupied,
  output logic               take,
  output spq_pkg::entry_t    entry,
  output spq_pkg::entry_t    entry_next
);
  import spq_pkg::*;

  // The new entry goes behind every entry of greater or equal priority, so
  // this cell yields only to a strictly higher priority or when it is empty.
  assign take = ctl.ins && (!occupied || (new_entry.prio > entry.prio));

  always_comb begin
    entry_next = entry;
    if (take) begin
      entry_next = prev_take ? prev_entry : new_entry;
    end else if (ctl.pop) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

[design/sorted_priority_queue.sv]
// An accepted request's result is registered at the accepting edge and shown on the master side.
// Throughput: one request per cycle while results drain; all cells update on the accepting edge.
// A new request is accepted while the result register is empty or being drained in the same cycle.
// Reset (rst, synchronous, active high) empties the queue and drops any pending result.
// Entry storage in the cells is not cleared; the count alone decides which cells hold entries.
`default_nettype none

module sorted_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0 up: priority_req[15:0], payload[31:16].
  input  logic [31:0] s_axis_tdata,
  // Fields from bit 0 up: kind[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0 up: popped_valid[0], popped_payload[16:1],
  // popped_priority[32:17], head_valid[33], head_payload[49:34],
  // head_priority[65:50], count[70:66], error[72:71], zero fill [79:73].
  output logic [79:0] m_axis_tdata
);
  import spq_pkg::*;

  // The queue is a row of DEPTH cells, cell 0 holding the head. Every cell
  // compares the incoming priority with its own entry in parallel; the cells
  // that yield form a contiguous tail of the list, so each yielding cell takes
  // its upper neighbor's entry except the first, which takes the new entry.
  // A pop shifts the whole row up by one cell.

  logic              accept;
  logic              out_valid;
  logic [79:0]       out_data;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [1:0]        kind;
  entry_t            req_entry;
  cell_ctl_t         ctl;
  logic              full;
  logic              empty;
  logic [1:0]        err;
  entry_t            popped;
  entry_t            head;
  logic              head_valid;

  entry_t            cell_q    [DEPTH];
  entry_t            cell_d    [DEPTH];
  logic              cell_take [DEPTH];

  assign kind           = s_axis_tuser;
  assign req_entry.prio = s_axis_tdata[15:0];
  assign req_entry.tag  = s_axis_tdata[31:16];

  // The result register may be refilled in the cycle it is drained.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign full  = (cnt == CNT_W'(DEPTH));
  assign empty = (cnt == '0);

  // An insert into a full queue and a pop of an empty queue leave the cells
  // untouched.
  assign ctl.ins = accept && (kind == KIND_INSERT) && !full;
  assign ctl.pop = accept && (kind == KIND_POP) && !empty;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_t prev_e;
      entry_t next_e;
      logic   prev_t;

      if (gi == 0) begin : g_first
        assign prev_e = cell_q[gi];
        assign prev_t = 1'b0;
      end else begin : g_mid
        assign prev_e = cell_q[gi-1];
        assign prev_t = cell_take[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        // The last cell is vacated by a pop; what it loads is never read.
        assign next_e = cell_q[gi];
      end else begin : g_inner
        assign next_e = cell_q[gi+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .new_entry  (req_entry),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .prev_take  (prev_t),
        .occupied   (cnt > CNT_W'(gi)),
        .take       (cell_take[gi]),
        .entry      (cell_q[gi]),
        .entry_next (cell_d[gi])
      );
    end
  endgenerate

  // Entry count and error code for the accepted request.
  always_comb begin
    cnt_next = cnt;
    err      = ERR_NONE;
    if (accept) begin
      case (kind)
        KIND_INSERT: begin
          if (full) begin
            err = ERR_FULL;
          end else begin
            cnt_next = cnt + CNT_W'(1);
          end
        end
        KIND_POP: begin
          if (empty) begin
            err = ERR_POP_EMPTY;
          end else begin
            cnt_next = cnt - CNT_W'(1);
          end
        end
        KIND_CLEAR: begin
          cnt_next = '0;
        end
        default: begin
          cnt_next = cnt;
        end
      endcase
    end
  end

  // The removed entry is the current head; fields read zero when no entry is removed.
  assign popped     = ctl.pop ? cell_q[0] : '0;
  assign head_valid = (cnt_next != '0);
  assign head       = head_valid ? cell_d[0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= {7'd0, err, COUNT_W'(cnt_next),
                   head.prio, head.tag, head_valid,
                   popped.prio, popped.tag, ctl.pop};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // The count never exceeds the number of cells.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count beyond queue depth");

  // An accepted clear always leaves the queue empty.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_CLEAR) |=> (cnt == '0))
    else $error("clear did not empty the queue");

  // The two head cells stay in priority order whenever both are occupied.
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (cnt >= CNT_W'(2)) |-> (cell_q[0].prio >= cell_q[1].prio))
    else $error("head entries out of priority order");

  // Without a clear the count moves by at most one per cycle.
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    !(accept && kind == KIND_CLEAR) |=>
      (cnt == $past(cnt) || cnt == $past(cnt) + CNT_W'(1) ||
       cnt == $past(cnt) - CNT_W'(1)))
    else $error("entry count jumped");

  // A reported removal always comes with a non-empty queue before it.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> !empty)
    else $error("pop issued on empty queue");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  // The block defines no name for the fourth kind code. A request of that kind is
  // ignored, but it still returns a report of the head and the count.
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  // This count is measured in requests other than the ignored kind.
  localparam int RANDOM_REQUESTS = 1800;
  // The receiver waits for this many results before it applies its one long back-pressure.
  localparam int HOLD_OFF_AFTER = 500;
  localparam int HOLD_OFF_CYCLES = 300;
  // A result is registered at the edge that accepts its request. The quiet edges at the end are
  // enough to catch a stray extra result.
  localparam int DRAIN_CYCLES = 8;
  // The longest quiet stretch in a correct run is the long hold-off. This limit is
  // several times that length.
  localparam int STALL_LIMIT = 3000;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] prio;
    logic [15:0]        tag;
    int unsigned        idle_before;   // Idle cycles the sender spends before offering this request.
  } request_t;

  // This struct has the layout of m_axis_tdata. The first member is the highest field.
  typedef struct packed {
    logic [6:0]         fill;
    logic [1:0]         err;
    logic [4:0]         count;
    logic signed [15:0] head_prio;
    logic [15:0]        head_tag;
    logic               head_valid;
    logic signed [15:0] pop_prio;
    logic [15:0]        pop_tag;
    logic               pop_valid;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = KIND_INSERT;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  sorted_priority_queue i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  request_t    pending_requests[$];
  report_t     expected_reports[$];
  request_t    in_flight;
  int unsigned idle_count = 0;
  int unsigned mismatches = 0;
  int unsigned result_index = 0;

  // Shadow copy of the queue contents. Slot 0 is the head. Slots at or above
  // shadow_count are stale and are never read.
  logic signed [15:0] shadow_prio[DEPTH];
  logic [15:0]        shadow_tag[DEPTH];
  int unsigned        shadow_count = 0;

  // Receiver state. Only the drain process below uses it.
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;
  int unsigned drained = 0;
  bit          held_off = 1'b0;

  // This function applies one accepted request to the shadow queue and returns the
  // report that the block must give for it. A new entry goes after every entry
  // whose priority is greater than or equal to its own, so entries of equal
  // priority leave in arrival order.
  function automatic report_t serve_request(request_t rq);
    report_t     res;
    int unsigned pos;
    res = '0;
    case (rq.kind)
      KIND_INSERT: begin
        if (shadow_count >= DEPTH) begin
          res.err = ERR_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_prio[pos] >= rq.prio) pos++;
          for (int k = shadow_count; k > pos; k--) begin
            shadow_prio[k] = shadow_prio[k-1];
            shadow_tag[k]  = shadow_tag[k-1];
          end
          shadow_prio[pos] = rq.prio;
          shadow_tag[pos]  = rq.tag;
          shadow_count++;
        end
      end
      KIND_POP: begin
        if (shadow_count == 0) begin
          res.err = ERR_POP_EMPTY;
        end else begin
          res.pop_valid = 1'b1;
          res.pop_tag   = shadow_tag[0];
          res.pop_prio  = shadow_prio[0];
          for (int k = 0; k + 1 < shadow_count; k++) begin
            shadow_prio[k] = shadow_prio[k+1];
            shadow_tag[k]  = shadow_tag[k+1];
          end
          shadow_count--;
        end
      end
      KIND_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    // When the queue is empty after the request, the head fields stay zero.
    if (shadow_count != 0) begin
      res.head_valid = 1'b1;
      res.head_tag   = shadow_tag[0];
      res.head_prio  = shadow_prio[0];
    end
    res.count = shadow_count[4:0];
    return res;
  endfunction

  // This task prints one line for each mismatch and counts it. After the first
  // few dozen lines it only counts, so a broken block cannot flood the log.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40) begin
      $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
               result_index, what, got, want);
    end
    mismatches++;
  endtask

  task automatic push_request(input logic [1:0] kind, input logic signed [15:0] prio,
                              input logic [15:0] tag, input int unsigned idle);
    request_t rq;
    rq.kind        = kind;
    rq.prio        = prio;
    rq.tag         = tag;
    rq.idle_before = idle;
    pending_requests.push_back(rq);
  endtask

  // Driver. At each edge it first records the request that the block accepted.
  // Then it offers the next request, or it idles for the gap that the request
  // carries. s_axis_tvalid gets at most one assignment per edge.
  always @(posedge clk) begin : drive_requests
    request_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      idle_count = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_reports.push_back(serve_request(in_flight));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() != 0 && idle_count >= pending_requests[0].idle_before) begin
          nxt = pending_requests.pop_front();
          in_flight = nxt;
          idle_count = 0;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {nxt.tag, nxt.prio};
          s_axis_tuser  <= nxt.kind;
        end else begin
          if (pending_requests.size() != 0) idle_count++;
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver. It mixes short stalls, a few long stalls and calm stretches in
  // which it never stalls. Once in the run it holds off for a long stretch. The
  // sender keeps offering requests during that stretch, so the result register
  // fills and the block stalls its input.
  always @(posedge clk) begin : drain_results
    int unsigned roll;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) drained++;
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!held_off && drained >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (calm_left != 0) begin
        calm_left--;
        m_axis_tready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          calm_left = $urandom_range(30, 150);
          m_axis_tready <= 1'b1;
        end else if (roll < 20) begin
          stall_left = $urandom_range(0, 2);
          m_axis_tready <= 1'b0;
        end else if (roll < 23) begin
          stall_left = $urandom_range(9, 39);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // Monitor. Each result that leaves the block is compared, field by field, with
  // the oldest report that is still waiting.
  always @(posedge clk) begin : check_reports
    report_t got;
    report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_reports.size() == 0) begin
        report_mismatch("result with no request waiting, count", 32'(got.count), '0);
      end else begin
        want = expected_reports.pop_front();
        if (got.pop_valid !== want.pop_valid)
          report_mismatch("popped_valid", 32'(got.pop_valid), 32'(want.pop_valid));
        if (got.pop_tag !== want.pop_tag)
          report_mismatch("popped_payload", 32'(got.pop_tag), 32'(want.pop_tag));
        if (got.pop_prio !== want.pop_prio)
          report_mismatch("popped_priority", 32'(got.pop_prio), 32'(want.pop_prio));
        if (got.head_valid !== want.head_valid)
          report_mismatch("head_valid", 32'(got.head_valid), 32'(want.head_valid));
        if (got.head_tag !== want.head_tag)
          report_mismatch("head_payload", 32'(got.head_tag), 32'(want.head_tag));
        if (got.head_prio !== want.head_prio)
          report_mismatch("head_priority", 32'(got.head_prio), 32'(want.head_prio));
        if (got.count !== want.count)
          report_mismatch("count", 32'(got.count), 32'(want.count));
        if (got.err !== want.err)
          report_mismatch("error", 32'(got.err), 32'(want.err));
        if (got.fill !== want.fill)
          report_mismatch("zero fill", 32'(got.fill), 32'(want.fill));
      end
      result_index++;
    end
  end

  // Watchdog. The run fails if no request and no result moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned        made;
    int unsigned        seg_len;
    int unsigned        mode;
    int unsigned        roll;
    int unsigned        idle;
    bit                 calm;
    logic [1:0]         k;
    logic signed [15:0] p;

    // Directed part. It starts on an empty queue with a pop, a clear and an
    // ignored request. Then come the priority extremes and a tie with the head.
    push_request(KIND_POP, 16'sh0000, 16'h0000, 0);
    push_request(KIND_CLEAR, 16'sh1357, 16'h2468, 0);
    push_request(KIND_IGNORED, 16'sh7fff, 16'hffff, 1);
    push_request(KIND_INSERT, 16'sh0000, 16'h0000, 0);
    push_request(KIND_INSERT, 16'sh7fff, 16'hffff, 0);
    push_request(KIND_INSERT, 16'sh8000, 16'h1234, 2);
    push_request(KIND_INSERT, 16'sh7fff, 16'haaaa, 0);
    push_request(KIND_IGNORED, 16'sh8000, 16'h0000, 0);
    // These twelve requests fill the queue. Their priorities are -1, 0 and 1, so
    // many of them tie. One more insert then hits the full queue.
    for (int i = 0; i < 12; i++) begin
      push_request(KIND_INSERT, 16'(i % 3 - 1), 16'(16'h5a00 + i), 0);
    end
    push_request(KIND_INSERT, 16'sh7fff, 16'h0f0f, 0);
    push_request(KIND_POP, 16'sh0000, 16'h0000, 0);
    push_request(KIND_CLEAR, 16'sh0000, 16'h0000, 0);

    // Random part. It is made of segments that mostly fill, mostly drain or mix,
    // so the queue keeps moving between empty and full. Half of the priorities
    // come from a narrow band, which produces many ties. The rest are either full
    // range or extreme values.
    made = 0;
    while (made < RANDOM_REQUESTS) begin
      seg_len = $urandom_range(20, 80);
      mode = $urandom_range(0, 2);
      calm = ($urandom_range(0, 3) == 0);
      repeat (seg_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) k = KIND_CLEAR;
        else if (roll < 3) k = KIND_IGNORED;
        else if (roll < (mode == 0 ? 78 : (mode == 1 ? 28 : 53))) k = KIND_INSERT;
        else k = KIND_POP;
        roll = $urandom_range(0, 9);
        if (roll < 5) begin
          p = 16'($urandom_range(0, 6) - 3);
        end else if (roll < 8) begin
          p = 16'($urandom());
        end else begin
          case ($urandom_range(0, 3))
            0: p = 16'sh8000;
            1: p = 16'sh7fff;
            2: p = -16'sd1;
            default: p = 16'sh0000;
          endcase
        end
        if (calm) begin
          idle = 0;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 65) idle = 0;
          else if (roll < 95) idle = $urandom_range(1, 3);
          else idle = $urandom_range(10, 40);
        end
        push_request(k, p, 16'($urandom()), idle);
        if (k != KIND_IGNORED) made++;
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // The state is sampled on falling edges, after all rising-edge updates have settled.
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_reports.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
